[hdl/assert_macros.svh]
// Assertion macros shared by the token classifier RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

[hdl/ctc_pkg.sv]
// Shared types for the calculator token classifier.
// No dependencies; used by all modules of the block.
package ctc_pkg;

    typedef enum logic [2:0] {
        CLS_INT      = 3'd0,
        CLS_RATIONAL = 3'd1,
        CLS_REAL     = 3'd2,
        CLS_COMPLEX  = 3'd3,
        CLS_ATOM     = 3'd4,
        CLS_EXPR     = 3'd5,
        CLS_PROGRAM  = 3'd6,
        CLS_UNKNOWN  = 3'd7
    } tok_class_t;

    typedef struct packed {
        logic       binary_op;
        logic       unary_op;
        tok_class_t token_class;
    } result_t;

endpackage

[hdl/ctc_out_reg.sv]
// Output register of the token classifier: holds one result word for the
// master side. Depends on ctc_pkg.
module ctc_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ctc_pkg::result_t result,
    output logic             load_ok,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata   // token_class[2:0], unary_op[3], binary_op[4]
);

    logic             valid_reg;
    ctc_pkg::result_t data_reg;

    assign load_ok       = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

[hdl/ctc_automata.sv]
// Per-class recognizers of the token classifier and the final classification.
// Depends on ctc_pkg.
module ctc_automata
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       char_code,
    input  logic             last_char,
    output ctc_pkg::result_t result
);

    typedef enum logic [2:0] {
        I_START = 3'd0, I_SIGN = 3'd1, I_DIG = 3'd2, I_ZERO = 3'd3, I_DEAD = 3'd7
    } int_state_t;

    typedef enum logic [2:0] {
        R_START = 3'd0, R_SIGN = 3'd1, R_NUM = 3'd2, R_SLASH = 3'd3,
        R_DSIGN = 3'd4, R_DEN = 3'd5, R_DEAD = 3'd7
    } rat_state_t;

    typedef enum logic [2:0] {
        F_START = 3'd0, F_INT = 3'd1, F_DOT = 3'd2, F_FRAC = 3'd3, F_DEAD = 3'd7
    } real_state_t;

    typedef enum logic [2:0] {
        P_START = 3'd0, P_NUM = 3'd1, P_DOT = 3'd2, P_SLASH = 3'd3,
        P_DSIGN = 3'd4, P_DEN = 3'd5, P_DEAD = 3'd7
    } part_state_t;

    typedef enum logic [1:0] {
        A_START = 2'd0, A_RUN = 2'd1, A_DEAD = 2'd2
    } atom_state_t;

    localparam int NumUnary  = 8;
    localparam int NumBinary = 17;
    localparam logic [2:0] LenSat = 3'd5;

    localparam logic [31:0] UNARY_WORDS [NumUnary] = '{
        "NOT", "NEG", "RE", "IM", "DEN", "NUM", "DROP", "DUP"
    };
    localparam logic [2:0] UNARY_LENS [NumUnary] = '{
        3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3
    };
    localparam logic [31:0] BINARY_WORDS [NumBinary] = '{
        "+", "-", "*", "/", "<", ">", "=", "<=", ">=", "!=",
        "DIV", "MOD", "$", "AND", "OR", "STO", "SWAP"
    };
    localparam logic [2:0] BINARY_LENS [NumBinary] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd1, 3'd3, 3'd2, 3'd3, 3'd4
    };

    // The newest character sits in the low byte, as do the last characters of the names.
    function automatic logic name_match(logic [31:0] hist, logic [2:0] len,
                                        logic [31:0] word, logic [2:0] wlen);
        logic [31:0] mask;
        mask = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < wlen)
            begin
                mask[i*8 +: 8] = 8'hFF;
            end
        end
        return (len == wlen) && ((hist & mask) == (word & mask));
    endfunction

    int_state_t  int_reg,  int_next;
    rat_state_t  rat_reg,  rat_next;
    real_state_t real_reg, real_next;
    logic        cx_after_reg, cx_after_next;
    part_state_t cx_part_reg,  cx_part_next;
    atom_state_t atom_reg, atom_next;
    logic [1:0]  delim_reg, delim_next;
    logic [2:0]  len_reg,   len_next;
    logic [31:0] hist_reg,  hist_next;

    logic is_dig, is_sign, is_upper, is_dot, is_slash, is_dollar, is_zero;
    logic two, unary_hit, binary_hit, cx_accept, cx_sep_ok;

    assign is_dig    = (char_code >= "0") && (char_code <= "9");
    assign is_sign   = (char_code == "+") || (char_code == "-");
    assign is_upper  = (char_code >= "A") && (char_code <= "Z");
    assign is_dot    = (char_code == ".");
    assign is_slash  = (char_code == "/");
    assign is_dollar = (char_code == "$");
    assign is_zero   = (char_code == "0");

    always_comb
    begin
        unique case (int_reg)
            I_START: int_next = is_sign ? I_SIGN : is_dig ? I_DIG : I_DEAD;
            I_SIGN:  int_next = is_dig ? I_DIG : I_DEAD;
            I_DIG:   int_next = is_dig ? I_DIG : is_dot ? I_ZERO : I_DEAD;
            I_ZERO:  int_next = is_zero ? I_ZERO : I_DEAD;
            default: int_next = I_DEAD;
        endcase

        unique case (rat_reg)
            R_START: rat_next = is_sign ? R_SIGN : is_dig ? R_NUM : R_DEAD;
            R_SIGN:  rat_next = is_dig ? R_NUM : R_DEAD;
            R_NUM:   rat_next = is_dig ? R_NUM : is_slash ? R_SLASH : R_DEAD;
            R_SLASH: rat_next = is_sign ? R_DSIGN : is_dig ? R_DEN : R_DEAD;
            R_DSIGN: rat_next = is_dig ? R_DEN : R_DEAD;
            R_DEN:   rat_next = is_dig ? R_DEN : R_DEAD;
            default: rat_next = R_DEAD;
        endcase

        unique case (real_reg)
            F_START: real_next = (is_sign || is_dig) ? F_INT : is_dot ? F_DOT : F_DEAD;
            F_INT:   real_next = is_dig ? F_INT : is_dot ? F_DOT : F_DEAD;
            F_DOT:   real_next = is_zero ? F_DOT : is_dig ? F_FRAC : F_DEAD;
            F_FRAC:  real_next = is_dig ? F_FRAC : F_DEAD;
            default: real_next = F_DEAD;
        endcase

        cx_sep_ok = (cx_part_reg == P_START) || (cx_part_reg == P_NUM) ||
                    (cx_part_reg == P_DOT) || (cx_part_reg == P_DEN);
        cx_after_next = cx_after_reg;
        if (is_dollar)
        begin
            cx_after_next = 1'b1;
            cx_part_next  = (!cx_after_reg && cx_sep_ok) ? P_START : P_DEAD;
        end
        else
        begin
            unique case (cx_part_reg)
                P_START: cx_part_next = (is_sign || is_dig) ? P_NUM : is_dot ? P_DOT :
                                        is_slash ? P_SLASH : P_DEAD;
                P_NUM:   cx_part_next = is_dig ? P_NUM : is_dot ? P_DOT :
                                        is_slash ? P_SLASH : P_DEAD;
                P_DOT:   cx_part_next = is_dig ? P_DOT : P_DEAD;
                P_SLASH: cx_part_next = is_sign ? P_DSIGN : is_dig ? P_DEN : P_DEAD;
                P_DSIGN: cx_part_next = is_dig ? P_DEN : P_DEAD;
                P_DEN:   cx_part_next = is_dig ? P_DEN : P_DEAD;
                default: cx_part_next = P_DEAD;
            endcase
        end
        cx_accept = cx_after_next &&
                    ((cx_part_next == P_START) || (cx_part_next == P_NUM) ||
                     (cx_part_next == P_DOT) || (cx_part_next == P_DEN));

        unique case (atom_reg)
            A_START: atom_next = is_upper ? A_RUN : A_DEAD;
            A_RUN:   atom_next = (is_upper || is_dig) ? A_RUN : A_DEAD;
            default: atom_next = A_DEAD;
        endcase

        len_next   = (len_reg < LenSat) ? len_reg + 3'd1 : len_reg;
        hist_next  = {hist_reg[23:0], char_code};
        delim_next = (len_reg == 3'd0) ? {char_code == "[", char_code == "'"} : delim_reg;
        two        = (len_next >= 3'd2);

        unary_hit = 1'b0;
        for (int i = 0; i < NumUnary; i++)
        begin
            unary_hit |= name_match(hist_next, len_next, UNARY_WORDS[i], UNARY_LENS[i]);
        end
        binary_hit = 1'b0;
        for (int i = 0; i < NumBinary; i++)
        begin
            binary_hit |= name_match(hist_next, len_next, BINARY_WORDS[i], BINARY_LENS[i]);
        end

        result.unary_op  = unary_hit;
        result.binary_op = binary_hit;
        priority if ((int_next == I_DIG) || (int_next == I_ZERO))
            result.token_class = ctc_pkg::CLS_INT;
        else if (rat_next == R_DEN)
            result.token_class = ctc_pkg::CLS_RATIONAL;
        else if (real_next == F_FRAC)
            result.token_class = ctc_pkg::CLS_REAL;
        else if (cx_accept)
            result.token_class = ctc_pkg::CLS_COMPLEX;
        else if (atom_next == A_RUN)
            result.token_class = ctc_pkg::CLS_ATOM;
        else if (two && delim_next[0] && (char_code == "'"))
            result.token_class = ctc_pkg::CLS_EXPR;
        else if (two && delim_next[1] && (char_code == "]"))
            result.token_class = ctc_pkg::CLS_PROGRAM;
        else
            result.token_class = ctc_pkg::CLS_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg      <= I_START;
            rat_reg      <= R_START;
            real_reg     <= F_START;
            cx_after_reg <= 1'b0;
            cx_part_reg  <= P_START;
            atom_reg     <= A_START;
            delim_reg    <= 2'b00;
            len_reg      <= 3'd0;
        end
        else if (advance)
        begin
            if (last_char)
            begin
                int_reg      <= I_START;
                rat_reg      <= R_START;
                real_reg     <= F_START;
                cx_after_reg <= 1'b0;
                cx_part_reg  <= P_START;
                atom_reg     <= A_START;
                delim_reg    <= 2'b00;
                len_reg      <= 3'd0;
            end
            else
            begin
                int_reg      <= int_next;
                rat_reg      <= rat_next;
                real_reg     <= real_next;
                cx_after_reg <= cx_after_next;
                cx_part_reg  <= cx_part_next;
                atom_reg     <= atom_next;
                delim_reg    <= delim_next;
                len_reg      <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

[hdl/calculator_token_classifier_top.sv]
// A token's result word is computed from the input register into ctc_out_reg.
// Throughput: one character per cycle; the input stalls only while a finished result
// waits on the master side and the next last character is already registered.
// Reset: rst_n clears all recognizers and valid flags asynchronously; a token in
// flight is dropped. Depends on ctc_pkg, ctc_automata, ctc_out_reg, assert_macros.svh.
`include "assert_macros.svh"

module calculator_token_classifier_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // char_code[7:0]
    input  logic       s_axis_tlast,   // last_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // token_class[2:0], unary_op[3], binary_op[4]
);

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_last_reg;
    logic             advance;
    logic             out_load_ok;
    ctc_pkg::result_t result;

    assign advance       = in_valid_reg && (!in_last_reg || out_load_ok);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    ctc_automata u_automata
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .result    (result)
    );

    ctc_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && in_last_reg),
        .result        (result),
        .load_ok       (out_load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_SAME(a_stall_only_on_full_output, clk, rst_n, !s_axis_tready,
                 m_axis_tvalid && !m_axis_tready)
    `ASSERT_NEXT(a_last_word_gives_result, clk, rst_n, advance && in_last_reg,
                 m_axis_tvalid)
    `ASSERT_SAME(a_result_needs_last_word, clk, rst_n, $rose(m_axis_tvalid),
                 $past(in_valid_reg && in_last_reg))

endmodule
